>>> hdl/insertion_sorter_top_assert.svh
// Assertion macros shared by the insertion sorter checker.
// Depends on clk and rst being visible where a macro is used.
`ifndef INSERTION_SORTER_TOP_ASSERT_SVH
`define INSERTION_SORTER_TOP_ASSERT_SVH

// Property holds in the same cycle as its antecedent.
`define ISRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isrt check failed");

// Property holds in the cycle after its antecedent.
`define ISRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isrt check failed");

`endif

>>> hdl/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; used by the sorter top, the cell and the checker.
package isrt_pkg;

  localparam int ISRT_MAX_ITEMS = 64;
  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_in;
    logic                      last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      last_out;
    logic                      overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t                mode;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } sorter_state_t;

endpackage

>>> hdl/insertion_sorter_top.sv
// Insertion sorter: a chain of MAX_ITEMS compare-and-shift cells.
// One request per cycle while loading; each element is written into place.
// After the request marked last, the state register turns to emission, then
// the output register loads results, one per cycle unless out_ready stalls;
// after the count empties, the state returns to taking requests. rst (synchronous)
// empties the list and output. Depends on isrt_pkg and isrt_cell.
module insertion_sorter_top #(
  parameter int MAX_ITEMS = isrt_pkg::ISRT_MAX_ITEMS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  isrt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output isrt_pkg::out_item_t  out_item
);
  import isrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  sorter_state_t state, state_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic dropped_flag, dropped_flag_next;

  logic in_accept, full, out_load, emit_done;
  cell_ctrl_t ctrl;

  logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_greater;
  logic [MAX_ITEMS-1:0] occupied;

  assign in_accept = in_valid && in_ready;
  assign full      = (fill_count == CNT_W'(MAX_ITEMS));
  assign emit_done = (fill_count == '0);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_accept && in_item.last_in) state_next = ST_EMIT;
      ST_EMIT: if (emit_done) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    in_ready   = (state == ST_LOAD);
    out_load   = (state == ST_EMIT) && !emit_done && (!out_valid || out_ready);
    ctrl.value = in_item.value_in;
    if (in_accept && !full) begin
      ctrl.mode = CELL_INSERT;
    end else if (out_load) begin
      ctrl.mode = CELL_SHIFT;
    end else begin
      ctrl.mode = CELL_HOLD;
    end
  end

  always_comb begin
    fill_count_next   = fill_count;
    dropped_flag_next = dropped_flag;
    if (in_accept) begin
      if (full) begin
        dropped_flag_next = 1'b1;
      end else begin
        fill_count_next = fill_count + CNT_W'(1);
      end
    end else if (out_load) begin
      fill_count_next = fill_count - CNT_W'(1);
    end else if (state == ST_EMIT && emit_done) begin
      dropped_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      fill_count   <= '0;
      dropped_flag <= 1'b0;
    end else begin
      state        <= state_next;
      fill_count   <= fill_count_next;
      dropped_flag <= dropped_flag_next;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;
    logic                      left_greater;

    assign occupied[i] = (fill_count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_value   = '0;
      assign left_greater = 1'b0;
    end else begin : g_body
      assign left_value   = cell_value[i-1];
      assign left_greater = cell_greater[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    isrt_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (occupied[i]),
      .left_value   (left_value),
      .left_greater (left_greater),
      .right_value  (right_value),
      .value        (cell_value[i]),
      .greater      (cell_greater[i])
    );
  end

  // Output register: the head cell is captured as the chain shifts down.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.value_out <= cell_value[0];
      out_item.last_out  <= (fill_count == CNT_W'(1));
      out_item.overflow  <= dropped_flag;
    end
  end

endmodule

>>> hdl/isrt_cell.sv
// One cell of the sorting chain: holds one stored value.
// Depends on isrt_pkg for the control struct and mode codes.
module isrt_cell (
  input  logic                                  clk,
  input  isrt_pkg::cell_ctrl_t                  ctrl,
  input  logic                                  occupied,
  input  logic signed [isrt_pkg::VALUE_W-1:0]   left_value,
  input  logic                                  left_greater,
  input  logic signed [isrt_pkg::VALUE_W-1:0]   right_value,
  output logic signed [isrt_pkg::VALUE_W-1:0]   value,
  output logic                                  greater
);
  import isrt_pkg::*;

  logic signed [VALUE_W-1:0] value_next;

  // Equal values stay in front of the new one, so only a strictly larger
  // stored value moves aside.
  assign greater = occupied && (value > ctrl.value);

  always_comb begin
    value_next = value;
    unique case (ctrl.mode)
      CELL_INSERT: begin
        if (left_greater) begin
          value_next = left_value;
        end else if (greater || !occupied) begin
          value_next = ctrl.value;
        end
      end
      CELL_SHIFT: value_next = right_value;
      default:    value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> hdl/isrt_checker.sv
// Port-level checks for the insertion sorter, bound to the top level.
// Depends on isrt_pkg and the macros in insertion_sorter_top_assert.svh.
`include "insertion_sorter_top_assert.svh"

module isrt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input isrt_pkg::in_item_t   in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input isrt_pkg::out_item_t  out_item
);
  import isrt_pkg::*;

  // A stalled result keeps its payload.
  `ISRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
  // The last request of a list starts emission, which blocks new requests.
  `ISRT_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && in_item.last_in, !in_ready)
  // While a result that is not the final one is pending, the list is still
  // being emitted and no request is taken.
  `ISRT_ASSERT_NOW(a_emit_blocks, out_valid && !out_item.last_out, !in_ready)
  // A result never appears right after an ordinary element is loaded.
  `ISRT_ASSERT_NEXT(a_no_early_out, in_valid && in_ready && !in_item.last_in && !out_valid,
                    !out_valid)

endmodule

bind insertion_sorter_top isrt_checker u_isrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
